[rtl/core/flagged_complex_mean_amp_phase_assert.svh]
// assertion macros for the flagged complex mean block
`ifndef FLAGGED_COMPLEX_MEAN_AMP_PHASE_ASSERT_SVH
`define FLAGGED_COMPLEX_MEAN_AMP_PHASE_ASSERT_SVH

// clocked assertion, off while reset is held
`define FCMAP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also runs through reset
`define FCMAP_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/fcmap_pkg.sv]
// shared constants, types and the arctangent table of the complex mean block
package fcmap_pkg;

    localparam int MAX_CHANNELS_DEF = 16384;
    localparam int SAMPLE_BITS      = 16;

    // mean magnitude and signed mean widths
    localparam int MEAN_W  = 17;
    localparam int SMEAN_W = MEAN_W + 1;
    // sum of squares and square root working width
    localparam int SQ_W    = 32;
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int SQK_W   = $clog2(SQ_STEPS);

    // vectoring rotator
    localparam int CORDIC_STEPS = 31;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int XY_W         = 34;
    localparam int ANGLE_W      = 37;
    localparam int NORM_LIMIT_LOG = 29;
    localparam int HALF_TURN    = 18000;
    localparam int PHASE_W      = 16;
    localparam int AMP_W        = 16;
    localparam int USED_W       = 15;
    localparam logic signed [ANGLE_W-1:0] HT_UNIT = ANGLE_W'(64'sd18000000000);

    // shared rounding divider
    localparam int DIV_N_W   = 38;
    localparam int DIV_D_W   = 21;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // angle to whole centidegrees: floor(t / 1e6) taken as
    // ((t >> 6) * Z_RECIP) >> 43, exact for t below the clamp limit
    localparam int ZN_W       = 29;
    localparam int ZR_W       = 30;
    localparam int Z_PRE_SH   = 6;
    localparam int Z_RECIP_SH = 43;
    localparam logic [ANGLE_W-1:0] Z_HALF    = ANGLE_W'(64'd500000);
    localparam logic [ANGLE_W-1:0] Z_SAT_LIM = ANGLE_W'(64'd18001000000);
    localparam logic [ZR_W-1:0]    Z_RECIP   = ZR_W'(64'd562949954);

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_RE,
        S_DIV_IM,
        S_SQ_RE,
        S_SQ_IM,
        S_SQ_ADD,
        S_SQRT,
        S_PH_PREP,
        S_NORM,
        S_CORDIC,
        S_Z_GO,
        S_DIV_Z,
        S_DONE
    } t_back_state;

    // atan(2^-i) in units of 1e-6 centidegree
    function automatic logic [ANGLE_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic [ANGLE_W-1:0] v;
        unique case (idx)
            5'd0:  v = ANGLE_W'(64'd4500000000);
            5'd1:  v = ANGLE_W'(64'd2656505118);
            5'd2:  v = ANGLE_W'(64'd1403624347);
            5'd3:  v = ANGLE_W'(64'd712501635);
            5'd4:  v = ANGLE_W'(64'd357633437);
            5'd5:  v = ANGLE_W'(64'd178991061);
            5'd6:  v = ANGLE_W'(64'd89517371);
            5'd7:  v = ANGLE_W'(64'd44761417);
            5'd8:  v = ANGLE_W'(64'd22381050);
            5'd9:  v = ANGLE_W'(64'd11190568);
            5'd10: v = ANGLE_W'(64'd5595289);
            5'd11: v = ANGLE_W'(64'd2797645);
            5'd12: v = ANGLE_W'(64'd1398823);
            5'd13: v = ANGLE_W'(64'd699411);
            5'd14: v = ANGLE_W'(64'd349706);
            5'd15: v = ANGLE_W'(64'd174853);
            5'd16: v = ANGLE_W'(64'd87426);
            5'd17: v = ANGLE_W'(64'd43713);
            5'd18: v = ANGLE_W'(64'd21857);
            5'd19: v = ANGLE_W'(64'd10928);
            5'd20: v = ANGLE_W'(64'd5464);
            5'd21: v = ANGLE_W'(64'd2732);
            5'd22: v = ANGLE_W'(64'd1366);
            5'd23: v = ANGLE_W'(64'd683);
            5'd24: v = ANGLE_W'(64'd342);
            5'd25: v = ANGLE_W'(64'd171);
            5'd26: v = ANGLE_W'(64'd85);
            5'd27: v = ANGLE_W'(64'd43);
            5'd28: v = ANGLE_W'(64'd21);
            5'd29: v = ANGLE_W'(64'd11);
            5'd30: v = ANGLE_W'(64'd5);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/fcmap_div.sv]
// bit-serial restoring divider with round-half-up on the quotient
module fcmap_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fcmap_pkg::t_div_req i_req,
    output fcmap_pkg::t_div_rsp o_rsp
);
    import fcmap_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N_W-1:0]   r_num;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W:0]     r_rem;
    logic [DIV_D_W-1:0]   r_den;

    logic [DIV_D_W:0]     trial;
    logic                 ge;
    logic                 round_up;

    assign trial    = {r_rem[DIV_D_W-1:0], r_num[DIV_N_W-1]};
    assign ge       = trial >= {1'b0, r_den};
    // remainder at least half the divisor rounds up
    assign round_up = {r_rem, 1'b0} >= {2'b00, r_den};

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo + DIV_N_W'(round_up);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_N_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_N_W-2:0], ge};
            r_rem <= ge ? (trial - {1'b0, r_den}) : trial;
        end
    end

endmodule

[rtl/core/fcmap_fifo.sv]
// short queue of finished vector sums between front and back
module fcmap_fifo #(
    parameter int WIDTH = 63
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import fcmap_pkg::*;

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_PTR_W:0]   r_fill;

    assign o_full  = r_fill == (Q_PTR_W + 1)'(Q_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/core/fcmap_front.sv]
// input side: accumulates unflagged samples and hands off vector totals
module fcmap_front #(
    parameter int MAX_CHANNELS = 16384,
    parameter int CNT_W        = 15,
    parameter int SUM_W        = 31,
    parameter int QW           = 2 * SUM_W + CNT_W + 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [fcmap_pkg::SAMPLE_BITS-1:0] i_real,
    input  logic signed [fcmap_pkg::SAMPLE_BITS-1:0] i_imag,
    input  logic                                i_flagged,
    input  logic                                i_last,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output logic [QW-1:0]                       o_q_data
);
    import fcmap_pkg::*;

    logic signed [SUM_W-1:0] r_re_sum;
    logic signed [SUM_W-1:0] r_im_sum;
    logic [CNT_W-1:0]        r_count;
    logic                    r_ovf;

    logic signed [SUM_W-1:0] n_re_sum;
    logic signed [SUM_W-1:0] n_im_sum;
    logic [CNT_W-1:0]        n_count;
    logic                    n_ovf;
    logic                    beat;
    logic                    room;

    assign o_ready = !i_q_full;
    assign beat    = i_valid && !i_q_full;
    assign room    = r_count < CNT_W'(MAX_CHANNELS);

    always_comb begin
        n_re_sum = r_re_sum;
        n_im_sum = r_im_sum;
        n_count  = r_count;
        n_ovf    = r_ovf;
        if (!i_flagged) begin
            if (room) begin
                n_re_sum = r_re_sum + SUM_W'(i_real);
                n_im_sum = r_im_sum + SUM_W'(i_imag);
                n_count  = r_count + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    assign o_q_push = beat && i_last;
    assign o_q_data = {n_ovf, n_count, n_im_sum, n_re_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_re_sum <= '0;
            r_im_sum <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
        end else if (beat) begin
            if (i_last) begin
                r_re_sum <= '0;
                r_im_sum <= '0;
                r_count  <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_re_sum <= n_re_sum;
                r_im_sum <= n_im_sum;
                r_count  <= n_count;
                r_ovf    <= n_ovf;
            end
        end
    end

endmodule

[rtl/core/fcmap_back.sv]
// result side: mean division, root of power, vectoring rotator, output register
module fcmap_back #(
    parameter int CNT_W = 15,
    parameter int SUM_W = 31,
    parameter int QW    = 2 * SUM_W + CNT_W + 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  logic [QW-1:0]                        i_q_data,
    output logic                                 o_q_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [fcmap_pkg::AMP_W-1:0]          o_amplitude,
    output logic signed [fcmap_pkg::PHASE_W-1:0] o_phase,
    output logic [fcmap_pkg::USED_W-1:0]         o_used_count,
    output logic                                 o_overflow
);
    import fcmap_pkg::*;

    localparam int CMP_W = (CNT_W > USED_W) ? CNT_W : USED_W;

    t_back_state r_state, n_state;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    logic signed [SUM_W-1:0]   r_re_sum, r_im_sum;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_ovf;
    logic signed [SMEAN_W-1:0] r_mr, r_mi;
    logic [SQ_W-1:0]           r_prod, r_rem, r_root;
    logic [SQK_W-1:0]          r_k;
    logic signed [XY_W-1:0]    r_x, r_y;
    logic signed [ANGLE_W-1:0] r_z;
    logic [STEP_W-1:0]         r_i;
    logic [AMP_W-1:0]          r_amp;
    logic signed [PHASE_W-1:0] r_ph;
    logic                      r_o_valid;
    logic                      r_z_sat;
    logic [ZN_W-1:0]           r_z_n;

    logic signed [SUM_W-1:0]   q_re, q_im;
    logic [CNT_W-1:0]          q_cnt;
    logic                      q_ovf;
    logic [SUM_W-1:0]          abs_q_re, abs_r_im;
    logic [ANGLE_W-1:0]        abs_z;
    logic [ANGLE_W-1:0]        z_rnd;
    logic [ZN_W+ZR_W-1:0]      z_prod;
    logic [MEAN_W-1:0]         quo_m;
    logic signed [SMEAN_W-1:0] mean_pos, mean_neg;
    logic signed [SMEAN_W-1:0] abs_mr, abs_mi;
    logic [MEAN_W-1:0]         mul_a;
    logic [2*MEAN_W-1:0]       prod_full;
    logic [SQ_W-1:0]           sq_bit, sq_trial, amp_full;
    logic signed [XY_W-1:0]    abs_x, abs_y, xs, ys;
    logic                      small_xy;
    logic [PHASE_W-1:0]        p_mag;
    logic [CMP_W-1:0]          cnt_wide;
    logic [USED_W-1:0]         cnt_sat;
    logic                      load_out;

    assign q_re  = i_q_data[SUM_W-1:0];
    assign q_im  = i_q_data[2*SUM_W-1:SUM_W];
    assign q_cnt = i_q_data[2*SUM_W+CNT_W-1:2*SUM_W];
    assign q_ovf = i_q_data[QW-1];

    assign abs_q_re = q_re[SUM_W-1] ? -q_re : q_re;
    assign abs_r_im = r_im_sum[SUM_W-1] ? -r_im_sum : r_im_sum;
    assign abs_z    = r_z[ANGLE_W-1] ? -r_z : r_z;

    assign quo_m    = div_rsp.quo[MEAN_W-1:0];
    assign mean_pos = $signed({1'b0, quo_m});
    assign mean_neg = -mean_pos;

    assign abs_mr    = r_mr[SMEAN_W-1] ? -r_mr : r_mr;
    assign abs_mi    = r_mi[SMEAN_W-1] ? -r_mi : r_mi;
    assign mul_a     = (r_state == S_SQ_RE) ? abs_mr[MEAN_W-1:0] : abs_mi[MEAN_W-1:0];
    assign prod_full = mul_a * mul_a;

    assign sq_bit   = SQ_W'(1) << (5'(SQ_W - 2) - 5'({r_k, 1'b0}));
    assign sq_trial = r_root + sq_bit;
    assign amp_full = r_root + SQ_W'(r_rem > r_root);

    assign abs_x    = r_x[XY_W-1] ? -r_x : r_x;
    assign abs_y    = r_y[XY_W-1] ? -r_y : r_y;
    assign small_xy = (abs_x < XY_W'(64'd1 << NORM_LIMIT_LOG))
                   && (abs_y < XY_W'(64'd1 << NORM_LIMIT_LOG));
    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;

    // angle magnitude rounded to centidegrees, reciprocal multiply on the
    // registered pre-shifted value, clamped to a half turn
    assign z_rnd  = abs_z + Z_HALF;
    assign z_prod = r_z_n * Z_RECIP;
    assign p_mag  = r_z_sat ? PHASE_W'(HALF_TURN) : z_prod[Z_RECIP_SH +: PHASE_W];

    assign cnt_wide = CMP_W'(r_cnt);
    assign cnt_sat  = (cnt_wide > CMP_W'({USED_W{1'b1}})) ? {USED_W{1'b1}}
                                                         : cnt_wide[USED_W-1:0];

    fcmap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_q_pop       = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        load_out      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (q_cnt == '0) begin
                        n_state = S_DONE;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.num   = DIV_N_W'(abs_q_re);
                        div_req.den   = DIV_D_W'(q_cnt);
                        n_state       = S_DIV_RE;
                    end
                end
            end
            S_DIV_RE: begin
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_N_W'(abs_r_im);
                    div_req.den   = DIV_D_W'(r_cnt);
                    n_state       = S_DIV_IM;
                end
            end
            S_DIV_IM: begin
                if (div_rsp.done) begin
                    n_state = S_SQ_RE;
                end
            end
            S_SQ_RE:  n_state = S_SQ_IM;
            S_SQ_IM:  n_state = S_SQ_ADD;
            S_SQ_ADD: n_state = S_SQRT;
            S_SQRT: begin
                if (r_k == SQK_W'(SQ_STEPS - 1)) begin
                    n_state = S_PH_PREP;
                end
            end
            S_PH_PREP: n_state = (r_mi == '0) ? S_DONE : S_NORM;
            S_NORM: begin
                if (!small_xy) begin
                    n_state = S_CORDIC;
                end
            end
            S_CORDIC: begin
                if (r_i == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_Z_GO;
                end
            end
            S_Z_GO:  n_state = S_DIV_Z;
            S_DIV_Z: n_state = S_DONE;
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    r_re_sum <= q_re;
                    r_im_sum <= q_im;
                    r_cnt    <= q_cnt;
                    r_ovf    <= q_ovf;
                    r_amp    <= '0;
                    r_ph     <= '0;
                end
            end
            S_DIV_RE: begin
                if (div_rsp.done) begin
                    r_mr <= r_re_sum[SUM_W-1] ? mean_neg : mean_pos;
                end
            end
            S_DIV_IM: begin
                if (div_rsp.done) begin
                    r_mi <= r_im_sum[SUM_W-1] ? mean_neg : mean_pos;
                end
            end
            S_SQ_RE: r_prod <= prod_full[SQ_W-1:0];
            S_SQ_IM: begin
                r_rem  <= r_prod;
                r_prod <= prod_full[SQ_W-1:0];
            end
            S_SQ_ADD: begin
                r_rem  <= r_rem + r_prod;
                r_root <= '0;
                r_k    <= '0;
            end
            S_SQRT: begin
                if (r_rem >= sq_trial) begin
                    r_rem  <= r_rem - sq_trial;
                    r_root <= (r_root >> 1) + sq_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_k <= r_k + 1'b1;
            end
            S_PH_PREP: begin
                r_amp <= (amp_full > SQ_W'({AMP_W{1'b1}})) ? {AMP_W{1'b1}}
                                                           : amp_full[AMP_W-1:0];
                r_i   <= '0;
                if (r_mi == '0) begin
                    r_ph <= r_mr[SMEAN_W-1] ? PHASE_W'(HALF_TURN) : '0;
                end else if (r_mr[SMEAN_W-1]) begin
                    // left half-plane: turn by a half circle first
                    r_x <= -XY_W'(r_mr);
                    r_y <= -XY_W'(r_mi);
                    r_z <= r_mi[SMEAN_W-1] ? -HT_UNIT : HT_UNIT;
                end else begin
                    r_x <= XY_W'(r_mr);
                    r_y <= XY_W'(r_mi);
                    r_z <= '0;
                end
            end
            S_NORM: begin
                if (small_xy) begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                end
            end
            S_CORDIC: begin
                if (!r_y[XY_W-1]) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + $signed(atan_lut(r_i));
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - $signed(atan_lut(r_i));
                end
                r_i <= r_i + 1'b1;
            end
            S_Z_GO: begin
                r_z_sat <= z_rnd >= Z_SAT_LIM;
                r_z_n   <= z_rnd[Z_PRE_SH +: ZN_W];
            end
            S_DIV_Z: begin
                r_ph <= r_z[ANGLE_W-1] ? -$signed(p_mag) : $signed(p_mag);
            end
            default: begin
            end
        endcase
    end

    // output register, frees the sequencer once the beat is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_amplitude  <= r_amp;
            o_phase      <= r_ph;
            o_used_count <= cnt_sat;
            o_overflow   <= r_ovf;
        end
    end

    assign o_valid = r_o_valid;

endmodule

[rtl/core/flagged_complex_mean_amp_phase.sv]
// top level of the flagged complex mean amplitude and phase block
//
//  channel | dir | bus group                      | contents
//  --------+-----+--------------------------------+--------------------------------------
//  input   | in  | i_tvalid i_tready i_tdata      | one visibility sample per beat
//          |     | i_tuser i_tlast                | tuser = flag, tlast = last of vector
//  result  | out | o_tvalid o_tready o_tdata      | one beat per vector
//          |     | o_tuser                        | tuser = count overflow
//
//  samples are taken one per cycle; the front accumulator never stalls unless
//  the two-entry vector queue is full
//  each nonempty vector passes the back sequencer through two mean divisions
//  on the bit-serial divider, squaring and 16 root steps and, unless the
//  imaginary mean is zero, normalizing, 31 rotator steps and the conversion
//  of the angle to centidegrees
//  reset is synchronous, active low, and empties queue, sums and output register
//  a stalled result beat holds in the output register while the front keeps
//  accumulating the next vector
module flagged_complex_mean_amp_phase #(
    parameter int MAX_CHANNELS = fcmap_pkg::MAX_CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    output logic        i_tready,
    input  logic [31:0] i_tdata,   // sample_real[15:0], sample_imag[31:16]
    input  logic        i_tuser,   // flagged
    input  logic        i_tlast,   // last_sample
    output logic        o_tvalid,
    input  logic        o_tready,
    output logic [47:0] o_tdata,   // amplitude[15:0], phase_centideg[31:16],
                                   // used_count[46:32], zero pad [47]
    output logic        o_tuser    // overflow
);
    import fcmap_pkg::*;

    // count must reach MAX_CHANNELS itself; sums carry one sample width on top
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int QW    = 2 * SUM_W + CNT_W + 1;

    logic signed [SAMPLE_BITS-1:0] s_real, s_imag;
    logic                          q_full, q_push, q_valid, q_pop;
    logic [QW-1:0]                 q_wdata, q_rdata;
    logic [AMP_W-1:0]              amp;
    logic signed [PHASE_W-1:0]     phase;
    logic [USED_W-1:0]             used;

    assign s_real = i_tdata[SAMPLE_BITS-1:0];
    assign s_imag = i_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // front: accumulate sums and count, hand totals off on the last beat
    fcmap_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CNT_W        (CNT_W),
        .SUM_W        (SUM_W),
        .QW           (QW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_tvalid),
        .o_ready   (i_tready),
        .i_real    (s_real),
        .i_imag    (s_imag),
        .i_flagged (i_tuser),
        .i_last    (i_tlast),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata)
    );

    // vector queue decouples accumulation from the slow back end
    fcmap_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    // back: rounded means, magnitude and phase
    fcmap_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W),
        .QW    (QW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_rdata),
        .o_q_pop      (q_pop),
        .o_valid      (o_tvalid),
        .i_ready      (o_tready),
        .o_amplitude  (amp),
        .o_phase      (phase),
        .o_used_count (used),
        .o_overflow   (o_tuser)
    );

    assign o_tdata = {1'b0, used, phase, amp};

endmodule

[rtl/core/flagged_complex_mean_amp_phase_chk.sv]
// port-level checker for the complex mean block and its bind
`include "flagged_complex_mean_amp_phase_assert.svh"

module flagged_complex_mean_amp_phase_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_tvalid,
    input logic        i_tready,
    input logic [31:0] i_tdata,
    input logic        i_tuser,
    input logic        i_tlast,
    input logic        o_tvalid,
    input logic        o_tready,
    input logic [47:0] o_tdata,
    input logic        o_tuser
);

    // result beat must wait until taken
    `FCMAP_ASSERT(a_out_hold, i_clk, i_rst_n, o_tvalid && !o_tready |=> o_tvalid, "result beat dropped before taken")

    // empty vector gives zero amplitude, zero phase and no overflow
    `FCMAP_ASSERT(a_empty_vec, i_clk, i_rst_n, o_tvalid && (o_tdata[46:32] == 15'd0) |-> (o_tdata[31:0] == 32'd0) && !o_tuser, "empty vector gave nonzero result")

    // phase stays within a half turn either way
    `FCMAP_ASSERT(a_phase_rng, i_clk, i_rst_n, o_tvalid |-> ($signed(o_tdata[31:16]) <= 16'sd18000) && ($signed(o_tdata[31:16]) >= -16'sd18000), "phase out of range")

    // reset empties the output register
    `FCMAP_ASSERT_NR(a_rst_idle, i_clk, !i_rst_n |=> !o_tvalid, "result beat valid after reset")

endmodule

bind flagged_complex_mean_amp_phase flagged_complex_mean_amp_phase_chk u_chk (.*);
